// File: hw/rtl/tage_branch_direction_predictor_defines.svh
// ----------------------------------------------------------------------------
// TAGE direction predictor assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TAGE_BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH
`define TAGE_BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TBDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("tbdp checker: implication failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TBDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbdp checker: next-cycle implication failed");

`endif

// File: hw/rtl/tbdp_pkg.sv
// ----------------------------------------------------------------------------
// TAGE direction predictor package
// Default geometry, opcodes, register resets and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbdp_pkg;

    localparam int NUM_TABLES_DEF        = 4;
    localparam int TABLE_INDEX_BITS_DEF  = 10;
    localparam int TAG_BITS_DEF          = 8;
    localparam int BASE_INDEX_BITS_DEF   = 12;
    localparam int HISTORY_BITS_DEF      = 128;
    localparam int CLEAR_PERIOD_BITS_DEF = 8;

    localparam int NUM_CFG_REGS = 4;
    localparam int CFG_ADDR_W   = 2;
    localparam int HLEN_W       = 7;

    localparam logic [HLEN_W-1:0] HLEN_RESET [NUM_CFG_REGS] = '{7'd5, 7'd12, 7'd27, 7'd60};

    localparam logic [1:0] OP_PREDICT = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_SHIFT   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] pc;
        logic        outcome;
        logic        predicted_dir;
        logic        alternate_dir;
        logic [2:0]  provider_table;
        logic [15:0] random_word;
    } req_t;

    typedef struct packed {
        logic       prediction;
        logic       alt_prediction;
        logic [2:0] provider;
        logic [2:0] alt_provider;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/tage_branch_direction_predictor.sv
// ----------------------------------------------------------------------------
// TAGE branch direction predictor
// Bimodal base table plus tagged tables, held in synchronous memories.
//
//   channel   handshake          payload     direction
//   request   start / busy       req         in
//   result    done (strobe)      rsp         out
//   config    cfg_wr_en          cfg_addr,   in
//                                cfg_wdata
//
// Predict: accept cycle, then the busy execute state; result strobed in the cycle after.
// Update: accept cycle, then the busy execute state; when a useful-row clear falls
// due, the clear-read and clear-write states follow it (extra read and write).
// History shift and unknown opcodes: taken in the accept cycle, no busy time.
// The busy time comes from the registered memory read followed by a modify-write.
// After reset a clearing pass over 2**max(BASE_INDEX_BITS, TABLE_INDEX_BITS)
// rows (4096 by default) holds busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tage_branch_direction_predictor #(
    parameter int NUM_TABLES        = tbdp_pkg::NUM_TABLES_DEF,
    parameter int TABLE_INDEX_BITS  = tbdp_pkg::TABLE_INDEX_BITS_DEF,
    parameter int TAG_BITS          = tbdp_pkg::TAG_BITS_DEF,
    parameter int BASE_INDEX_BITS   = tbdp_pkg::BASE_INDEX_BITS_DEF,
    parameter int HISTORY_BITS      = tbdp_pkg::HISTORY_BITS_DEF,
    parameter int CLEAR_PERIOD_BITS = tbdp_pkg::CLEAR_PERIOD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire tbdp_pkg::req_t                  req,
    output logic                                 done,
    output tbdp_pkg::rsp_t                       rsp,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tbdp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tbdp_pkg::HLEN_W-1:0]     cfg_wdata
);
    import tbdp_pkg::*;

    localparam int ROWS      = 1 << TABLE_INDEX_BITS;
    localparam int BASE_ROWS = 1 << BASE_INDEX_BITS;
    localparam int CLR_W     = CLEAR_PERIOD_BITS + TABLE_INDEX_BITS + 1;
    localparam int SW_BITS   = (BASE_INDEX_BITS > TABLE_INDEX_BITS) ?
                               BASE_INDEX_BITS : TABLE_INDEX_BITS;

    typedef struct packed {
        logic [2:0]          ctr;
        logic [TAG_BITS-1:0] tag;
        logic [1:0]          useful;
    } entry_t;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_CLRA, S_CLRB} state_t;

    state_t state_reg, state_next;
    logic   done_next;
    rsp_t   rsp_reg, rsp_next;

    logic [HLEN_W-1:0]           hist_len_reg [NUM_CFG_REGS];
    logic [HLEN_W-1:0]           hist_len_use [NUM_TABLES];
    logic [TABLE_INDEX_BITS-1:0] idx_fold [NUM_TABLES];
    logic [TAG_BITS-1:0]         tag_fold_a [NUM_TABLES];
    logic [TAG_BITS-2:0]         tag_fold_b [NUM_TABLES];
    logic [TABLE_INDEX_BITS-1:0] row_now [NUM_TABLES];
    logic [TAG_BITS-1:0]         tag_now [NUM_TABLES];

    logic                        accept;
    logic [SW_BITS-1:0]          sweep_reg;
    req_t                        item_reg;
    logic [TABLE_INDEX_BITS-1:0] row_reg [NUM_TABLES];
    logic [TAG_BITS-1:0]         tag_reg [NUM_TABLES];
    logic [BASE_INDEX_BITS-1:0]  base_idx_reg;
    logic                        rnd_zero_reg;
    logic                        rnd_zero_next;
    logic [CLR_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                        clr_due;
    logic [TABLE_INDEX_BITS-1:0] clr_row_reg;
    logic                        clr_msb_reg;

    entry_t                      tbl_rd_reg [NUM_TABLES];
    entry_t                      tbl_wd [NUM_TABLES];
    logic                        tbl_we [NUM_TABLES];
    logic [TABLE_INDEX_BITS-1:0] tbl_wa [NUM_TABLES];
    logic [TABLE_INDEX_BITS-1:0] tbl_ra [NUM_TABLES];
    logic [1:0]                  base_rd_reg;
    logic [1:0]                  base_wd;
    logic                        base_we;
    logic [BASE_INDEX_BITS-1:0]  base_wa;

    function automatic logic [2:0] ctr_step(input logic [2:0] v, input logic up);
        logic [2:0] r;
        if (up)
            r = (v == 3'd7) ? v : v + 3'd1;
        else
            r = (v == 3'd0) ? v : v - 3'd1;
        return r;
    endfunction

    function automatic logic [1:0] u_step(input logic [1:0] v, input logic up);
        logic [1:0] r;
        if (up)
            r = (v == 2'd3) ? v : v + 2'd1;
        else
            r = (v == 2'd0) ? v : v - 2'd1;
        return r;
    endfunction

    function automatic logic mod3_zero(input logic [15:0] x);
        logic [4:0] s;
        logic [2:0] s2;
        s = '0;
        for (int i = 0; i < 8; i++)
            s = s + 5'(x[2*i +: 2]);
        s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        return (s2 inside {3'd0, 3'd3, 3'd6});
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG_REGS; i++)
                hist_len_reg[i] <= HLEN_RESET[i];
        end
        else if (cfg_wr_en)
        begin
            hist_len_reg[cfg_addr] <= cfg_wdata;
        end
    end

    for (genvar t = 0; t < NUM_TABLES; t++) begin : g_hlen
        assign hist_len_use[t] = hist_len_reg[t];
    end

    assign accept = start && (state_reg == S_IDLE);

    tbdp_history #(
        .NUM_TABLES      (NUM_TABLES),
        .TABLE_INDEX_BITS(TABLE_INDEX_BITS),
        .TAG_BITS        (TAG_BITS),
        .HISTORY_BITS    (HISTORY_BITS)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept && (req.opcode == OP_SHIFT)),
        .shift_bit (req.outcome),
        .hist_len  (hist_len_use),
        .idx_fold  (idx_fold),
        .tag_fold_a(tag_fold_a),
        .tag_fold_b(tag_fold_b)
    );

    always_comb
    begin
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            row_now[t] = idx_fold[t] ^ req.pc[2 +: TABLE_INDEX_BITS];
            tag_now[t] = tag_fold_a[t] ^ {1'b0, tag_fold_b[t]} ^ req.pc[2 +: TAG_BITS];
        end
    end

    assign rnd_zero_next = mod3_zero(req.random_word);

    // latch the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= req;
            row_reg      <= row_now;
            tag_reg      <= tag_now;
            base_idx_reg <= req.pc[BASE_INDEX_BITS-1:0];
            rnd_zero_reg <= rnd_zero_next;
        end
    end

    // clearing sweep and useful-clear period counter
    assign clr_cnt_next = clr_cnt_reg + CLR_W'(1);
    assign clr_due      = (clr_cnt_next[CLEAR_PERIOD_BITS-1:0] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            clr_cnt_reg <= '0;
            clr_row_reg <= '0;
            clr_msb_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
                sweep_reg <= sweep_reg + SW_BITS'(1);
            if ((state_reg == S_EXEC) && (item_reg.opcode == OP_UPDATE))
            begin
                clr_cnt_reg <= clr_cnt_next;
                clr_row_reg <= clr_cnt_next[CLEAR_PERIOD_BITS +: TABLE_INDEX_BITS];
                clr_msb_reg <= clr_cnt_next[CLR_W-1];
            end
        end
    end

    // memories
    for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
        entry_t tbl_mem [ROWS];
        always_ff @(posedge clk)
        begin
            if (tbl_we[t])
                tbl_mem[tbl_wa[t]] <= tbl_wd[t];
            tbl_rd_reg[t] <= tbl_mem[tbl_ra[t]];
        end
        assign tbl_ra[t] = (state_reg == S_CLRA) ? clr_row_reg : row_now[t];
    end

    logic [1:0] base_mem [BASE_ROWS];
    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[base_wa] <= base_wd;
        base_rd_reg <= base_mem[req.pc[BASE_INDEX_BITS-1:0]];
    end

    // modify and write back
    always_comb
    begin
        logic [2:0] prov;
        logic       found;
        logic       mispred;
        logic       alloc_ok;
        logic [2:0] start_t;
        logic       first_f;
        logic       second_f;
        logic [2:0] first_i;
        logic [2:0] second_i;
        logic [2:0] victim;
        entry_t     e;
        logic       we;
        logic       upd;

        upd      = (state_reg == S_EXEC) && (item_reg.opcode == OP_UPDATE);
        prov     = (item_reg.provider_table > 3'(NUM_TABLES)) ?
                   3'(NUM_TABLES) : item_reg.provider_table;
        found    = (prov < 3'(NUM_TABLES));
        mispred  = (item_reg.predicted_dir != item_reg.outcome);
        alloc_ok = mispred && (!found || ((4'(prov) + 4'd2) <= 4'(NUM_TABLES)));
        start_t  = found ? prov + 3'd1 : 3'd0;
        first_f  = 1'b0;
        second_f = 1'b0;
        first_i  = '0;
        second_i = '0;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            if (alloc_ok && (3'(t) >= start_t) && (tbl_rd_reg[t].useful == 2'd0))
            begin
                if (!first_f)
                begin
                    first_f = 1'b1;
                    first_i = 3'(t);
                end
                else if (!second_f)
                begin
                    second_f = 1'b1;
                    second_i = 3'(t);
                end
            end
        end
        victim = (second_f && rnd_zero_reg) ? second_i : first_i;

        for (int t = 0; t < NUM_TABLES; t++)
        begin
            e  = tbl_rd_reg[t];
            we = 1'b0;
            if (found && (3'(t) == prov))
            begin
                if (item_reg.predicted_dir != item_reg.alternate_dir)
                    e.useful = u_step(e.useful, !mispred);
                e.ctr = ctr_step(e.ctr, item_reg.outcome);
                we    = 1'b1;
            end
            if (alloc_ok && (3'(t) >= start_t))
            begin
                if (!first_f)
                begin
                    e.useful = u_step(e.useful, 1'b0);
                    we       = 1'b1;
                end
                else if (3'(t) == victim)
                begin
                    e.tag    = tag_reg[t];
                    e.ctr    = item_reg.outcome ? 3'd4 : 3'd3;
                    e.useful = 2'd0;
                    we       = 1'b1;
                end
            end

            case (state_reg)
                S_CLEAR:
                begin
                    tbl_we[t] = 1'b1;
                    tbl_wa[t] = sweep_reg[TABLE_INDEX_BITS-1:0];
                    tbl_wd[t] = '0;
                end
                S_CLRB:
                begin
                    tbl_we[t] = 1'b1;
                    tbl_wa[t] = clr_row_reg;
                    tbl_wd[t] = tbl_rd_reg[t];
                    tbl_wd[t].useful = tbl_rd_reg[t].useful & (clr_msb_reg ? 2'd1 : 2'd2);
                end
                default:
                begin
                    tbl_we[t] = upd && we;
                    tbl_wa[t] = row_reg[t];
                    tbl_wd[t] = e;
                end
            endcase
        end

        if (state_reg == S_CLEAR)
        begin
            base_we = 1'b1;
            base_wa = sweep_reg[BASE_INDEX_BITS-1:0];
            base_wd = 2'd0;
        end
        else
        begin
            base_we = upd && !found;
            base_wa = base_idx_reg;
            base_wd = u_step(base_rd_reg, item_reg.outcome);
        end
    end

    // lookup result
    always_comb
    begin
        logic pf;
        logic af;
        logic base_dir;
        base_dir = base_rd_reg[1];
        pf       = 1'b0;
        af       = 1'b0;
        rsp_next.prediction     = base_dir;
        rsp_next.alt_prediction = base_dir;
        rsp_next.provider       = 3'(NUM_TABLES);
        rsp_next.alt_provider   = 3'(NUM_TABLES);
        for (int t = NUM_TABLES - 1; t >= 0; t--)
        begin
            if (tbl_rd_reg[t].tag == tag_reg[t])
            begin
                if (!pf)
                begin
                    pf = 1'b1;
                    rsp_next.provider   = 3'(t);
                    rsp_next.prediction = tbl_rd_reg[t].ctr[2];
                end
                else if (!af)
                begin
                    af = 1'b1;
                    rsp_next.alt_provider   = 3'(t);
                    rsp_next.alt_prediction = tbl_rd_reg[t].ctr[2];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (sweep_reg == '1)
                    state_next = S_IDLE;
            S_IDLE:
                if (accept && ((req.opcode == OP_PREDICT) || (req.opcode == OP_UPDATE)))
                    state_next = S_EXEC;
            S_EXEC:
                if ((item_reg.opcode == OP_UPDATE) && clr_due)
                    state_next = S_CLRA;
                else
                    state_next = S_IDLE;
            S_CLRA:
                state_next = S_CLRB;
            S_CLRB:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign done_next = (state_reg == S_EXEC) && (item_reg.opcode == OP_PREDICT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
            rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tbdp_history.sv
// ----------------------------------------------------------------------------
// TAGE global and folded history
// Holds the global history shift register and the per-table index and tag folds.
// ----------------------------------------------------------------------------
`default_nettype none

module tbdp_history #(
    parameter int NUM_TABLES       = tbdp_pkg::NUM_TABLES_DEF,
    parameter int TABLE_INDEX_BITS = tbdp_pkg::TABLE_INDEX_BITS_DEF,
    parameter int TAG_BITS         = tbdp_pkg::TAG_BITS_DEF,
    parameter int HISTORY_BITS     = tbdp_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift_en,
    input  wire logic                        shift_bit,
    input  wire logic [tbdp_pkg::HLEN_W-1:0] hist_len [NUM_TABLES],
    output logic [TABLE_INDEX_BITS-1:0]      idx_fold [NUM_TABLES],
    output logic [TAG_BITS-1:0]              tag_fold_a [NUM_TABLES],
    output logic [TAG_BITS-2:0]              tag_fold_b [NUM_TABLES]
);
    import tbdp_pkg::*;

    localparam int HB      = $clog2(HISTORY_BITS);
    localparam int LEN_CNT = 1 << HLEN_W;

    logic [HISTORY_BITS-1:0]     ghist_reg;
    logic [HISTORY_BITS-1:0]     ghist_next;
    logic [TABLE_INDEX_BITS-1:0] idx_fold_reg [NUM_TABLES];
    logic [TAG_BITS-1:0]         fold_a_reg [NUM_TABLES];
    logic [TAG_BITS-2:0]         fold_b_reg [NUM_TABLES];
    logic [TABLE_INDEX_BITS-1:0] idx_fold_next [NUM_TABLES];
    logic [TAG_BITS-1:0]         fold_a_next [NUM_TABLES];
    logic [TAG_BITS-2:0]         fold_b_next [NUM_TABLES];
    logic [3:0]                  pos_i_tab [LEN_CNT];
    logic [3:0]                  pos_a_tab [LEN_CNT];
    logic [3:0]                  pos_b_tab [LEN_CNT];

    for (genvar i = 0; i < LEN_CNT; i++) begin : g_pos
        assign pos_i_tab[i] = 4'(i % TABLE_INDEX_BITS);
        assign pos_a_tab[i] = 4'(i % TAG_BITS);
        assign pos_b_tab[i] = 4'(i % (TAG_BITS - 1));
    end

    assign ghist_next = {ghist_reg[HISTORY_BITS-2:0], shift_bit};

    always_comb
    begin
        logic [8:0] len9;
        logic       lbit;
        len9 = '0;
        lbit = 1'b0;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            len9 = 9'(hist_len[t]);
            lbit = (len9 < 9'(HISTORY_BITS)) ? ghist_next[len9[HB-1:0]] : 1'b0;
            idx_fold_next[t] = {idx_fold_reg[t][TABLE_INDEX_BITS-2:0],
                                shift_bit ^ idx_fold_reg[t][TABLE_INDEX_BITS-1]}
                               ^ (TABLE_INDEX_BITS'(lbit) << pos_i_tab[hist_len[t]]);
            fold_a_next[t] = {fold_a_reg[t][TAG_BITS-2:0],
                              shift_bit ^ fold_a_reg[t][TAG_BITS-1]}
                             ^ (TAG_BITS'(lbit) << pos_a_tab[hist_len[t]]);
            fold_b_next[t] = {fold_b_reg[t][TAG_BITS-3:0],
                              shift_bit ^ fold_b_reg[t][TAG_BITS-2]}
                             ^ ((TAG_BITS-1)'(lbit) << pos_b_tab[hist_len[t]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghist_reg <= '0;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                idx_fold_reg[t] <= '0;
                fold_a_reg[t]   <= '0;
                fold_b_reg[t]   <= '0;
            end
        end
        else if (shift_en)
        begin
            ghist_reg <= ghist_next;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                idx_fold_reg[t] <= idx_fold_next[t];
                fold_a_reg[t]   <= fold_a_next[t];
                fold_b_reg[t]   <= fold_b_next[t];
            end
        end
    end

    assign idx_fold   = idx_fold_reg;
    assign tag_fold_a = fold_a_reg;
    assign tag_fold_b = fold_b_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tbdp_checker.sv
// ----------------------------------------------------------------------------
// TAGE direction predictor port checker
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tage_branch_direction_predictor_defines.svh"

module tbdp_checker #(
    parameter int NUM_TABLES = tbdp_pkg::NUM_TABLES_DEF
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire tbdp_pkg::req_t req,
    input wire logic           done,
    input wire tbdp_pkg::rsp_t rsp
);
    import tbdp_pkg::*;

    `TBDP_ASSERT_IMP(a_done_after_busy, done, $past(busy))
    `TBDP_ASSERT_NEXT(a_done_single, done, !done)
    `TBDP_ASSERT_IMP(a_predict_result, start && !busy && (req.opcode == OP_PREDICT), ##2 done)
    `TBDP_ASSERT_IMP(a_alt_below_provider, done, (rsp.alt_provider == 3'(NUM_TABLES)) || (rsp.alt_provider < rsp.provider))

endmodule

bind tage_branch_direction_predictor tbdp_checker #(
    .NUM_TABLES(NUM_TABLES)
) u_tbdp_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
);

`default_nettype wire

// File: tb/tage_branch_direction_predictor_checker.sv
// ----------------------------------------------------------------------------
// TAGE direction predictor checker
// Watches the request, result and config ports, keeps its own copy of the
// predictor tables and histories, and compares every result with the oldest
// expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tage_branch_direction_predictor_checker
    import tbdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_t                  req,
    input  logic                  done,
    input  rsp_t                  rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [HLEN_W-1:0]     cfg_wdata,
    output int                    pending,
    output int                    errors
);
    localparam int NT  = NUM_TABLES_DEF;
    localparam int IB  = TABLE_INDEX_BITS_DEF;
    localparam int TB  = TAG_BITS_DEF;
    localparam int BB  = BASE_INDEX_BITS_DEF;
    localparam int HB  = HISTORY_BITS_DEF;
    localparam int CPB = CLEAR_PERIOD_BITS_DEF;
    localparam int CW  = CPB + IB + 1;

    logic [HLEN_W-1:0] hist_len [NUM_CFG_REGS];
    logic [1:0]        base_ctr [1 << BB];
    logic [2:0]        dir_ctr  [NT][1 << IB];
    logic [TB-1:0]     tags     [NT][1 << IB];
    logic [1:0]        useful   [NT][1 << IB];
    logic [HB-1:0]     ghist;
    logic [IB-1:0]     fold_idx [NT];
    logic [TB-1:0]     fold_ta  [NT];
    logic [TB-2:0]     fold_tb  [NT];
    logic [CW-1:0]     clr_ctr;
    rsp_t              expected_rsp [$];

    function automatic logic [IB-1:0] row_of(int t, logic [31:0] pc);
        return fold_idx[t] ^ pc[IB+1:2];
    endfunction

    function automatic logic [TB-1:0] tag_of(int t, logic [31:0] pc);
        return fold_ta[t] ^ {1'b0, fold_tb[t]} ^ pc[TB+1:2];
    endfunction

    function automatic logic hbit(int pos);
        return (pos >= HB) ? 1'b0 : ghist[pos];
    endfunction

    function automatic rsp_t lookup(logic [31:0] pc);
        rsp_t r;
        int prov;
        int alt;
        logic base_dir;
        prov = NT;
        alt = NT;
        for (int t = NT - 1; t >= 0; t--) begin
            if (tags[t][row_of(t, pc)] == tag_of(t, pc)) begin
                if (prov == NT) prov = t;
                else if (alt == NT) alt = t;
            end
        end
        base_dir = base_ctr[pc[BB-1:0]] >= 2;
        r.prediction = (prov < NT) ? dir_ctr[prov][row_of(prov, pc)] >= 4 : base_dir;
        r.alt_prediction = (alt < NT) ? dir_ctr[alt][row_of(alt, pc)] >= 4 : base_dir;
        r.provider = prov[2:0];
        r.alt_provider = alt[2:0];
        return r;
    endfunction

    task automatic train(req_t q);
        logic [IB-1:0] rw [NT];
        int prov;
        int first;
        int second;
        int victim;
        int lo;
        logic [IB-1:0] cr;
        for (int t = 0; t < NT; t++) rw[t] = row_of(t, q.pc);
        prov = (q.provider_table > NT) ? NT : q.provider_table;
        if (prov < NT) begin
            if (q.predicted_dir != q.alternate_dir) begin
                if (q.predicted_dir == q.outcome) begin
                    if (useful[prov][rw[prov]] != 3) useful[prov][rw[prov]]++;
                end else if (useful[prov][rw[prov]] != 0) useful[prov][rw[prov]]--;
            end
            if (q.outcome) begin
                if (dir_ctr[prov][rw[prov]] != 7) dir_ctr[prov][rw[prov]]++;
            end else if (dir_ctr[prov][rw[prov]] != 0) dir_ctr[prov][rw[prov]]--;
        end else begin
            if (q.outcome) begin
                if (base_ctr[q.pc[BB-1:0]] != 3) base_ctr[q.pc[BB-1:0]]++;
            end else if (base_ctr[q.pc[BB-1:0]] != 0) base_ctr[q.pc[BB-1:0]]--;
        end
        if (q.predicted_dir != q.outcome && (prov == NT || prov + 2 <= NT)) begin
            lo = (prov < NT) ? prov + 1 : 0;
            first = NT;
            second = NT;
            for (int t = lo; t < NT; t++) begin
                if (useful[t][rw[t]] == 0 && second == NT) begin
                    if (first == NT) first = t;
                    else second = t;
                end
            end
            if (first == NT) begin
                for (int t = lo; t < NT; t++)
                    if (useful[t][rw[t]] != 0) useful[t][rw[t]]--;
            end else begin
                victim = (second < NT && q.random_word % 3 == 0) ? second : first;
                tags[victim][rw[victim]] = tag_of(victim, q.pc);
                dir_ctr[victim][rw[victim]] = q.outcome ? 3'd4 : 3'd3;
                useful[victim][rw[victim]] = 2'd0;
            end
        end
        clr_ctr = clr_ctr + 1'b1;
        if (clr_ctr[CPB-1:0] == '0) begin
            cr = clr_ctr[CPB+IB-1:CPB];
            for (int t = 0; t < NT; t++)
                useful[t][cr] &= clr_ctr[CW-1] ? 2'b01 : 2'b10;
        end
    endtask

    task automatic shift_history(logic nb);
        int len;
        ghist = {ghist[HB-2:0], nb};
        for (int t = 0; t < NT; t++) begin
            len = hist_len[t];
            fold_idx[t] = {fold_idx[t][IB-2:0], nb ^ fold_idx[t][IB-1]};
            fold_idx[t][len % IB] ^= hbit(len);
            fold_ta[t] = {fold_ta[t][TB-2:0], nb ^ fold_ta[t][TB-1]};
            fold_ta[t][len % TB] ^= hbit(len);
            fold_tb[t] = {fold_tb[t][TB-3:0], nb ^ fold_tb[t][TB-2]};
            fold_tb[t][len % (TB - 1)] ^= hbit(len);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t e;
        if (!rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) hist_len[i] = HLEN_RESET[i];
            foreach (base_ctr[i]) base_ctr[i] = '0;
            for (int t = 0; t < NT; t++) begin
                foreach (dir_ctr[t][i]) begin
                    dir_ctr[t][i] = '0;
                    tags[t][i] = '0;
                    useful[t][i] = '0;
                end
                fold_idx[t] = '0;
                fold_ta[t] = '0;
                fold_tb[t] = '0;
            end
            ghist = '0;
            clr_ctr = '0;
            expected_rsp.delete();
            pending = 0;
            errors = 0;
        end else begin
            if (done) begin
                if (expected_rsp.size() == 0) begin
                    $error("unexpected result %p", rsp);
                    errors++;
                end else begin
                    e = expected_rsp.pop_front();
                    if (rsp.prediction !== e.prediction) begin
                        $error("prediction: expected %0d actual %0d", e.prediction,
                               rsp.prediction);
                        errors++;
                    end
                    if (rsp.alt_prediction !== e.alt_prediction) begin
                        $error("alt_prediction: expected %0d actual %0d",
                               e.alt_prediction, rsp.alt_prediction);
                        errors++;
                    end
                    if (rsp.provider !== e.provider) begin
                        $error("provider: expected %0d actual %0d", e.provider,
                               rsp.provider);
                        errors++;
                    end
                    if (rsp.alt_provider !== e.alt_provider) begin
                        $error("alt_provider: expected %0d actual %0d", e.alt_provider,
                               rsp.alt_provider);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                case (req.opcode)
                    OP_PREDICT: expected_rsp.push_back(lookup(req.pc));
                    OP_UPDATE:  train(req);
                    OP_SHIFT:   shift_history(req.outcome);
                    default: ;
                endcase
            end
            if (cfg_wr_en) hist_len[cfg_addr] = cfg_wdata;
            pending = expected_rsp.size();
        end
    end
endmodule

// File: tb/tb_tage_branch_direction_predictor.sv
// ----------------------------------------------------------------------------
// TAGE direction predictor testbench
// Drives directed and random predict, update, history and unknown-opcode
// transactions with random idle bursts across several history-length settings;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tage_branch_direction_predictor;
    import tbdp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    req_t                  req = '0;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [HLEN_W-1:0]     cfg_wdata = '0;
    int                    pending;
    int                    errors;
    int                    cycles = 0;
    logic [31:0]           hot_pcs [8];
    logic                  quiet = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tage_branch_direction_predictor dut (.*);

    tage_branch_direction_predictor_checker u_checker (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(req_t q);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_len(int idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx[CFG_ADDR_W-1:0];
        cfg_wdata <= val[HLEN_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic req_t rand_req(logic [1:0] op);
        req_t q;
        q.opcode = op;
        q.pc = ($urandom_range(0, 3) == 0) ? $urandom() : hot_pcs[$urandom_range(0, 7)];
        q.outcome = $urandom_range(0, 1);
        q.predicted_dir = $urandom_range(0, 1);
        q.alternate_dir = $urandom_range(0, 1);
        q.provider_table = $urandom_range(0, 7);
        q.random_word = $urandom_range(0, 65535);
        return q;
    endfunction

    task automatic random_phase(int n);
        req_t q;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 7) q = rand_req(OP_PREDICT);
            else if (pick < 13) q = rand_req(OP_UPDATE);
            else if (pick < 19) q = rand_req(OP_SHIFT);
            else q = rand_req(2'd3);
            if (q.opcode == OP_UPDATE && $urandom_range(0, 1) == 1)
                q.provider_table = $urandom_range(0, 4);
            send(q);
        end
    endtask

    initial begin
        req_t q;
        foreach (hot_pcs[i]) hot_pcs[i] = $urandom();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        q = '0;
        send(q);
        q.pc = 32'hFFFF_FFFF;
        send(q);
        q = '{OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 3'd7, 16'hFFFF};
        send(q);
        q = '{OP_UPDATE, 32'h0, 1'b0, 1'b1, 1'b0, 3'd4, 16'h0};
        send(q);
        q = '{OP_UPDATE, 32'h0, 1'b1, 1'b0, 1'b1, 3'd3, 16'd3};
        send(q);
        q = '{OP_UPDATE, 32'h0, 1'b1, 1'b0, 1'b0, 3'd0, 16'd1};
        send(q);
        for (int i = 0; i < 6; i++) begin
            q = '{OP_SHIFT, 32'h0, i[0], 1'b0, 1'b0, 3'd0, 16'd0};
            send(q);
        end
        q = '{2'd3, 32'h1234_5678, 1'b1, 1'b1, 1'b1, 3'd2, 16'd5};
        send(q);
        q = '{OP_PREDICT, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 16'd0};
        send(q);
        drain();

        write_len(0, 0);
        write_len(1, 127);
        write_len(2, 1);
        write_len(3, 126);
        random_phase(350);
        drain();

        write_len(0, 127);
        write_len(1, 0);
        write_len(2, 64);
        write_len(3, 128 - 1);
        random_phase(350);
        drain();

        write_len(0, 5);
        write_len(1, 12);
        write_len(2, 27);
        write_len(3, 60);
        random_phase(400);
        drain();

        quiet = 1'b1;
        random_phase(400);
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: tage_branch_direction_predictor.f
+incdir+hw/rtl
hw/rtl/tbdp_pkg.sv
hw/rtl/tbdp_history.sv
hw/rtl/tage_branch_direction_predictor.sv
hw/rtl/tbdp_checker.sv
tb/tage_branch_direction_predictor_checker.sv
tb/tb_tage_branch_direction_predictor.sv
